/* hw/rtl/gdil_pkg.sv */
// gdil_pkg: shared types and codes for the grid obstacle dilation block.
// Used by grid_obstacle_dilation and its port checker gdil_chk.
// No dependencies.
package gdil_pkg;

  // Request kinds carried in req_type and echoed in done_kind
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_GRID_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_RADIUS        = 2'd2;
  localparam logic [1:0] CFG_OBSTACLE_CODE = 2'd3;

  // Register reset values
  localparam logic [8:0] RST_GRID_WIDTH    = 9'd256;
  localparam logic [8:0] RST_GRID_HEIGHT   = 9'd256;
  localparam logic [7:0] RST_RADIUS        = 8'd0;
  localparam logic [7:0] RST_OBSTACLE_CODE = 8'd100;

  // Input word
  typedef struct packed {
    logic [1:0]        req_type;
    logic [7:0]        cell_x;
    logic [7:0]        cell_y;
    logic signed [7:0] cell_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic signed [7:0] read_value;
    logic [1:0]        done_kind;
  } out_word_t;

endpackage

/* hw/rtl/grid_obstacle_dilation.sv */
// grid_obstacle_dilation: occupancy grid store with in-place obstacle inflation.
// Depends on gdil_pkg (word types, request and register codes).
// Checker gdil_chk is bound to this module from its own file.
//
//   channel | ports                          | word / meaning
//   --------+--------------------------------+-----------------------------------
//   input   | in_valid, in_stall, in_data    | in_word_t: write, read, run
//   result  | out_valid, out_stall, out_data | out_word_t: one per request
//   config  | cfg_we, cfg_index, cfg_wdata   | width, height, radius, code
//
// Writes and reads take one word per cycle while in_stall is low; a read result
// passes the cell memory read register, then the output register.
// A run makes radius passes: each pass is one raster sweep of (w+1)*(h+1) positions
// through the cell memory's single read port, then a flush state (ST_GAP).
// A run with zero width, height or radius goes from drain straight to done.
// Reset clears control and config only; the cell memory has no clearing pass.
// A stalled result holds; while the read stage is full and the result register
// is full and stalled, or a run is in progress, in_stall is high.
module grid_obstacle_dilation #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdil_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output gdil_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [8:0]          cfg_wdata
);
  import gdil_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int CWX   = (WW > 9) ? WW : 9;
  localparam int CWY   = (HW > 9) ? HW : 9;
  localparam int AW    = XW + YW;
  localparam int CELLS = 1 << AW;

  typedef enum logic [2:0] {ST_IDLE, ST_DRAIN, ST_SCAN, ST_GAP, ST_DONE} state_t;

  // Config registers
  logic [8:0] grid_w_r, grid_h_r;
  logic [7:0] radius_r, code_r;

  // Control
  state_t          state_r, state_nxt;
  logic            s1_v_r, s1_v_nxt;
  logic [1:0]      s1_kind_r, s1_kind_nxt;
  logic            s1_inside_r, s1_inside_nxt;
  logic            out_v_r, out_v_nxt;
  out_word_t       out_r, out_nxt;
  logic [WW-1:0]   sx_r, sx_nxt;
  logic [HW-1:0]   sy_r, sy_nxt;
  logic [7:0]      pass_r, pass_nxt;
  logic            p_v_r, p_v_nxt;
  logic            p_real_r, p_real_nxt;
  logic [WW-1:0]   px_r, px_nxt;
  logic [HW-1:0]   py_r, py_nxt;
  logic [2:0]      c1_r, c1_nxt, c2_r, c2_nxt;

  // Memories and their ports
  logic [7:0]    cell_mem [0:CELLS-1];
  logic [1:0]    row_buf  [0:MAX_WIDTH-1];
  logic [7:0]    cell_rd_r;
  logic [1:0]    lb_rd_r;
  logic          cell_re, cell_we;
  logic [AW-1:0] cell_raddr, cell_waddr;
  logic [7:0]    cell_wdata;
  logic          lb_re, lb_we;
  logic [XW-1:0] lb_raddr, lb_waddr;
  logic [1:0]    lb_wdata;

  // Effective grid size, clipped to the maximum
  logic [WW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  assign eff_w = (CWX'(grid_w_r) > CWX'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(grid_w_r);
  assign eff_h = (CWY'(grid_h_r) > CWY'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(grid_h_r);

  // Handshake
  logic in_acc, out_free, s1_move, req_inside;
  logic [AW-1:0] req_addr;
  assign out_free   = !out_v_r || !out_stall;
  assign in_stall   = (state_r != ST_IDLE) || (s1_v_r && !out_free);
  assign in_acc     = in_valid && !in_stall;
  assign s1_move    = s1_v_r && out_free;
  assign req_inside = (CWX'(in_data.cell_x) < CWX'(eff_w)) &&
                      (CWY'(in_data.cell_y) < CWY'(eff_h));
  assign req_addr   = {YW'(in_data.cell_y), XW'(in_data.cell_x)};
  assign out_valid  = out_v_r;
  assign out_data   = out_r;

  // Sweep window: column at px holds marks of rows py-2, py-1, py
  logic          col_in, m_cur, mk_a, mk_b, win;
  logic [2:0]    cur, c1e, c2e;
  logic [WW-1:0] px_m1;
  logic [HW-1:0] py_m1;
  assign col_in = (px_r != eff_w);
  assign m_cur  = p_real_r && (cell_rd_r == code_r);
  assign mk_a   = col_in && (py_r > HW'(1)) && lb_rd_r[1];
  assign mk_b   = col_in && (py_r != '0) && lb_rd_r[0];
  assign cur    = {mk_a, mk_b, m_cur};
  assign c1e    = (px_r != '0) ? c1_r : 3'b000;
  assign c2e    = (px_r > WW'(1)) ? c2_r : 3'b000;
  assign win    = |{cur, c1e, c2e};
  assign px_m1  = px_r - WW'(1);
  assign py_m1  = py_r - HW'(1);

  // Next-state logic
  always_comb begin
    state_nxt     = state_r;
    s1_v_nxt      = s1_v_r;
    s1_kind_nxt   = s1_kind_r;
    s1_inside_nxt = s1_inside_r;
    out_v_nxt     = out_v_r && out_stall;
    out_nxt       = out_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    pass_nxt      = pass_r;
    p_v_nxt       = 1'b0;
    p_real_nxt    = 1'b0;
    px_nxt        = sx_r;
    py_nxt        = sy_r;
    c1_nxt        = c1_r;
    c2_nxt        = c2_r;
    cell_re       = 1'b0;
    cell_raddr    = req_addr;
    cell_we       = 1'b0;
    cell_waddr    = req_addr;
    cell_wdata    = in_data.cell_value;
    lb_re         = 1'b0;
    lb_raddr      = XW'(sx_r);
    lb_we         = 1'b0;
    lb_waddr      = XW'(px_r);
    lb_wdata      = {mk_b, m_cur};

    // Read stage to result register
    if (s1_move) begin
      s1_v_nxt            = 1'b0;
      out_v_nxt           = 1'b1;
      out_nxt.done_kind   = s1_kind_r;
      out_nxt.read_value  = (s1_kind_r == REQ_READ && s1_inside_r) ? cell_rd_r : 8'sd0;
    end

    // Request acceptance
    if (in_acc) begin
      if (in_data.req_type == REQ_RUN) begin
        state_nxt = ST_DRAIN;
      end else begin
        s1_v_nxt      = 1'b1;
        s1_kind_nxt   = in_data.req_type;
        s1_inside_nxt = req_inside;
        cell_re       = (in_data.req_type == REQ_READ) && req_inside;
        cell_we       = (in_data.req_type == REQ_WRITE) && req_inside;
      end
    end

    // Sweep results: write back inflated cells and the row buffer
    if (p_v_r) begin
      c1_nxt = cur;
      c2_nxt = c1_r;
      lb_we  = col_in;
      if (px_r != '0 && py_r != '0 && win) begin
        cell_we    = 1'b1;
        cell_waddr = {YW'(py_m1), XW'(px_m1)};
        cell_wdata = code_r;
      end
    end

    case (state_r)
      ST_IDLE: begin
      end
      ST_DRAIN: begin
        if (!s1_v_r) begin
          sx_nxt   = '0;
          sy_nxt   = '0;
          pass_nxt = '0;
          if (eff_w == '0 || eff_h == '0 || radius_r == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        p_v_nxt    = 1'b1;
        p_real_nxt = (sx_r < eff_w) && (sy_r < eff_h);
        cell_re    = p_real_nxt;
        cell_raddr = {YW'(sy_r), XW'(sx_r)};
        lb_re      = (sx_r < eff_w);
        if (sx_r == eff_w) begin
          sx_nxt = '0;
          if (sy_r == eff_h) begin
            sy_nxt    = '0;
            state_nxt = ST_GAP;
          end else begin
            sy_nxt = sy_r + HW'(1);
          end
        end else begin
          sx_nxt = sx_r + WW'(1);
        end
      end
      ST_GAP: begin
        // last sweep position drains here before the next pass reads
        pass_nxt = pass_r + 8'd1;
        if (pass_r == radius_r - 8'd1) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_v_nxt          = 1'b1;
          out_nxt.done_kind  = REQ_RUN;
          out_nxt.read_value = 8'sd0;
          state_nxt          = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      p_v_r    <= 1'b0;
      sx_r     <= '0;
      sy_r     <= '0;
      pass_r   <= '0;
      grid_w_r <= RST_GRID_WIDTH;
      grid_h_r <= RST_GRID_HEIGHT;
      radius_r <= RST_RADIUS;
      code_r   <= RST_OBSTACLE_CODE;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
      p_v_r   <= p_v_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      pass_r  <= pass_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:    grid_w_r <= cfg_wdata;
          CFG_GRID_HEIGHT:   grid_h_r <= cfg_wdata;
          CFG_RADIUS:        radius_r <= cfg_wdata[7:0];
          CFG_OBSTACLE_CODE: code_r   <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_kind_r   <= s1_kind_nxt;
    s1_inside_r <= s1_inside_nxt;
    out_r       <= out_nxt;
    p_real_r    <= p_real_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    c1_r        <= c1_nxt;
    c2_r        <= c2_nxt;
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rd_r <= cell_mem[cell_raddr];
    end
  end

  // Row buffer: obstacle marks of the two rows above the sweep
  always_ff @(posedge clk) begin
    if (lb_we) begin
      row_buf[lb_waddr] <= lb_wdata;
    end
    if (lb_re) begin
      lb_rd_r <= row_buf[lb_raddr];
    end
  end

endmodule

/* hw/rtl/gdil_chk.sv */
// gdil_chk: port-level checker for grid_obstacle_dilation, bound to the top.
// Depends on gdil_pkg (word types, request codes).
// Tracks words accepted but not yet delivered.
module gdil_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input gdil_pkg::in_word_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input gdil_pkg::out_word_t out_data
);
  import gdil_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_r, pend_nxt;

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign pend_nxt = pend_r + {1'b0, in_acc} - {1'b0, out_acc};

  // Outstanding request count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // A run blocks new words in the following cycle
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.req_type == REQ_RUN |=> in_stall)
    else $error("input accepted right after a run");

  // No result without an outstanding request
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result word with no request outstanding");

  // At most three requests in flight
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r == 2'd3 && in_acc && !out_acc))
    else $error("too many requests in flight");

endmodule

bind grid_obstacle_dilation gdil_chk u_gdil_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* bench/grid_obstacle_dilation_tb.sv */
`timescale 1ns / 100ps
// grid_obstacle_dilation_tb: self-checking bench for the grid obstacle dilation block.
// Keeps its own grid copy to predict every result word; needs gdil_pkg and the block RTL.

// Grid copy and result bookkeeping
class occupancy_model;
  localparam int GRID_MAX = 256;

  bit [7:0] cell_val [GRID_MAX*GRID_MAX];
  bit       cell_set [GRID_MAX*GRID_MAX];
  int       grid_w;
  int       grid_h;
  int       steps;
  bit [7:0] obst;
  gdil_pkg::out_word_t expected_replies[$];
  int       mismatch_count;

  function new();
    grid_w = int'(gdil_pkg::RST_GRID_WIDTH);
    grid_h = int'(gdil_pkg::RST_GRID_HEIGHT);
    steps  = int'(gdil_pkg::RST_RADIUS);
    obst   = gdil_pkg::RST_OBSTACLE_CODE;
    mismatch_count = 0;
  endfunction

  // sizes past the array clip to the array
  function int eff_w();
    return grid_w > GRID_MAX ? GRID_MAX : grid_w;
  endfunction

  function int eff_h();
    return grid_h > GRID_MAX ? GRID_MAX : grid_h;
  endfunction

  function void write_reg(logic [1:0] idx, logic [8:0] val);
    case (idx)
      gdil_pkg::CFG_GRID_WIDTH:    grid_w = int'(val);
      gdil_pkg::CFG_GRID_HEIGHT:   grid_h = int'(val);
      gdil_pkg::CFG_RADIUS:        steps = int'(val[7:0]);
      gdil_pkg::CFG_OBSTACLE_CODE: obst = val[7:0];
      default: ;
    endcase
  endfunction

  // Square dilation, done as a row spread then a column spread of the
  // obstacle map taken before the run
  function void inflate();
    bit src_hit[];
    bit row_hit[];
    int w, h, x, y, k, lo, hi;
    bit hit;
    w = eff_w();
    h = eff_h();
    if (w == 0 || h == 0 || steps == 0) return;
    src_hit = new[w*h];
    row_hit = new[w*h];
    for (y = 0; y < h; y++)
      for (x = 0; x < w; x++)
        src_hit[y*w+x] = (cell_val[y*GRID_MAX+x] == obst);
    for (y = 0; y < h; y++)
      for (x = 0; x < w; x++) begin
        hit = 1'b0;
        lo = (x - steps < 0) ? 0 : x - steps;
        hi = (x + steps > w - 1) ? w - 1 : x + steps;
        for (k = lo; k <= hi; k++)
          if (src_hit[y*w+k]) hit = 1'b1;
        row_hit[y*w+x] = hit;
      end
    for (x = 0; x < w; x++)
      for (y = 0; y < h; y++) begin
        hit = 1'b0;
        lo = (y - steps < 0) ? 0 : y - steps;
        hi = (y + steps > h - 1) ? h - 1 : y + steps;
        for (k = lo; k <= hi; k++)
          if (row_hit[k*w+x]) hit = 1'b1;
        if (hit) cell_val[y*GRID_MAX+x] = obst;
      end
  endfunction

  // Accepted input word: update the grid and queue the result it causes
  function void accept_request(gdil_pkg::in_word_t word);
    gdil_pkg::out_word_t reply;
    int addr;
    bit in_grid;
    in_grid = (int'(word.cell_x) < eff_w()) && (int'(word.cell_y) < eff_h());
    addr = int'(word.cell_y) * GRID_MAX + int'(word.cell_x);
    reply.read_value = '0;
    reply.done_kind  = word.req_type;
    case (word.req_type)
      gdil_pkg::REQ_WRITE:
        if (in_grid) begin
          cell_val[addr] = word.cell_value;
          cell_set[addr] = 1'b1;
        end
      gdil_pkg::REQ_READ:
        if (in_grid) reply.read_value = cell_val[addr];
      gdil_pkg::REQ_RUN:
        inflate();
      default: ;
    endcase
    expected_replies = {expected_replies, reply};
  endfunction

  function void check_reply(gdil_pkg::out_word_t got);
    gdil_pkg::out_word_t want;
    if (expected_replies.size() == 0) begin
      $error("result word with none expected: read_value %0d done_kind %0d",
             got.read_value, got.done_kind);
      mismatch_count++;
      return;
    end
    want = expected_replies.pop_front();
    if (got.read_value !== want.read_value) begin
      $error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
      mismatch_count++;
    end
    if (got.done_kind !== want.done_kind) begin
      $error("done_kind: expected %0d, got %0d", want.done_kind, got.done_kind);
      mismatch_count++;
    end
  endfunction

  function void finish_check();
    if (expected_replies.size() != 0) begin
      $error("%0d result words never arrived", expected_replies.size());
      mismatch_count++;
    end
  endfunction
endclass

module grid_obstacle_dilation_tb;
  import gdil_pkg::*;

  localparam int RUN_ITEMS   = 1300;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;  // no operation, echoed back

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_data;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_word_t  out_data;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_wdata;

  occupancy_model grid_ref;
  int send_gap_pct = 11;
  int recv_gap_pct = 49;
  int words_sent   = 0;
  int cycle_count  = 0;
  bit hold_req     = 1'b0;
  bit hold_seen    = 1'b0;
  int hold_left    = 0;

  grid_obstacle_dilation DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_obstacle_dilation_tb: done, errors");
      $finish;
    end
  end

  // Handshake monitor: values seen here are the ones at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) grid_ref.accept_request(in_data);
      if (out_valid && !out_stall) grid_ref.check_reply(out_data);
    end
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else
      out_stall <= ($urandom_range(99) < recv_gap_pct);
  end

  function automatic in_word_t make_word(logic [1:0] kind, logic [7:0] x, logic [7:0] y,
                                         logic [7:0] v);
    in_word_t word;
    word.req_type   = kind;
    word.cell_x     = x;
    word.cell_y     = y;
    word.cell_value = v;
    return word;
  endfunction

  // Offer one word, with random idle cycles first, and wait until taken
  task automatic send_word(in_word_t word);
    if (words_sent < RUN_ITEMS / 3) begin
      send_gap_pct = 11;
      recv_gap_pct = 49;
    end else if (words_sent < 2 * RUN_ITEMS / 3) begin
      send_gap_pct = 49;
      recv_gap_pct = 11;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Wait until every result is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (grid_ref.expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(logic [8:0] w, logic [8:0] h, logic [7:0] r, logic [7:0] code);
    logic [1:0] idx [4];
    logic [8:0] val [4];
    int i;
    idx = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_RADIUS, CFG_OBSTACLE_CODE};
    val = '{w, h, {1'b0, r}, {1'b0, code}};
    for (i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
      grid_ref.write_reg(idx[i], val[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Write every cell of the grid in use that holds no value yet
  task automatic fill_grid();
    int x, y;
    logic [7:0] v;
    for (y = 0; y < grid_ref.eff_h(); y++)
      for (x = 0; x < grid_ref.eff_w(); x++)
        if (!grid_ref.cell_set[y*256+x]) begin
          v = ($urandom_range(7) == 0) ? grid_ref.obst : 8'($urandom);
          send_word(make_word(REQ_WRITE, 8'(x), 8'(y), v));
        end
  endtask

  // Mixed traffic on a fully written grid
  task automatic random_mix(int count);
    int i, roll, ew, eh;
    logic [1:0] kind;
    logic [7:0] x, y, v;
    ew = grid_ref.eff_w();
    eh = grid_ref.eff_h();
    for (i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (ew > 0 && eh > 0 && $urandom_range(99) < 85) begin
        x = 8'($urandom_range(ew - 1));
        y = 8'($urandom_range(eh - 1));
      end else begin
        x = 8'($urandom);
        y = 8'($urandom);
      end
      v = ($urandom_range(5) == 0) ? grid_ref.obst : 8'($urandom);
      if (roll < 8)       kind = REQ_RUN;
      else if (roll < 10) kind = REQ_UNKNOWN;
      else if (roll < 55) kind = REQ_WRITE;
      else                kind = REQ_READ;
      send_word(make_word(kind, x, y, v));
    end
  endtask

  initial begin
    int phase;
    int w, h, r;
    logic [7:0] code;
    grid_ref  = new();
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_GRID_WIDTH;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Full default grid: corner cells, value extremes, unknown request,
    // a run with radius zero that must leave the cells alone
    send_word(make_word(REQ_WRITE, 8'h00, 8'h00, 8'h7F));
    send_word(make_word(REQ_WRITE, 8'hFF, 8'hFF, 8'h80));
    send_word(make_word(REQ_WRITE, 8'hFF, 8'h00, 8'd100));
    send_word(make_word(REQ_WRITE, 8'h00, 8'hFF, 8'h55));
    send_word(make_word(REQ_READ, 8'h00, 8'h00, 8'h00));
    send_word(make_word(REQ_READ, 8'hFF, 8'hFF, 8'hFF));
    send_word(make_word(REQ_READ, 8'hFF, 8'h00, 8'h00));
    send_word(make_word(REQ_READ, 8'h00, 8'hFF, 8'h00));
    send_word(make_word(REQ_UNKNOWN, 8'hAA, 8'h55, 8'h33));
    send_word(make_word(REQ_RUN, 8'h00, 8'h00, 8'h00));
    send_word(make_word(REQ_READ, 8'h00, 8'hFF, 8'h00));
    drain();

    // Zero width: writes dropped, reads give zero, run does nothing
    configure(9'd0, 9'd256, 8'd3, 8'd100);
    send_word(make_word(REQ_WRITE, 8'h00, 8'h00, 8'h05));
    send_word(make_word(REQ_READ, 8'h00, 8'h00, 8'h00));
    send_word(make_word(REQ_RUN, 8'h00, 8'h00, 8'h00));
    drain();
    // Zero height
    configure(9'd4, 9'd0, 8'd3, 8'd100);
    send_word(make_word(REQ_WRITE, 8'h01, 8'h00, 8'h64));
    send_word(make_word(REQ_READ, 8'hFF, 8'h00, 8'h00));
    send_word(make_word(REQ_RUN, 8'h00, 8'h00, 8'h00));
    drain();

    // Phases: a few fixed corner settings, then random small grids
    phase = 0;
    while (words_sent < RUN_ITEMS) begin
      case (phase)
        0: configure(9'd4, 9'd4, 8'd255, 8'h80);
        1: configure(9'd511, 9'd1, 8'd2, 8'h7F);
        2: configure(9'd1, 9'd511, 8'd1, 8'($urandom));
        default: begin
          if ($urandom_range(4) == 0) begin
            w = $urandom_range(13, 40);
            h = $urandom_range(1, 3);
          end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
          end
          r = ($urandom_range(5) == 0) ? 0 : $urandom_range(1, (w > 12) ? 3 : 6);
          if ($urandom_range(3) == 0)
            code = $urandom_range(1) ? 8'h80 : 8'h7F;
          else
            code = 8'($urandom);
          configure(9'(w), 9'(h), 8'(r), code);
        end
      endcase
      fill_grid();
      // long receiver hold-off so the block backs up into its input
      if (phase == 0) hold_req <= ~hold_req;
      random_mix($urandom_range(20, 60));
      drain();
      phase++;
    end

    repeat (20) @(posedge clk);
    grid_ref.finish_check();
    if (grid_ref.mismatch_count == 0)
      $display("grid_obstacle_dilation_tb: done, clean");
    else
      $display("grid_obstacle_dilation_tb: done, errors");
    $finish;
  end
endmodule

/* files.f */
hw/rtl/gdil_pkg.sv
hw/rtl/grid_obstacle_dilation.sv
hw/rtl/gdil_chk.sv
bench/grid_obstacle_dilation_tb.sv
